FILE: hdl/tsqm_pkg.sv
// Shared widths, codes and time constants for the timestamp-aligned queue merge.
`default_nettype none
package tsqm_pkg;

    // Field widths fixed by the record format
    localparam int SRC_W  = 3;
    localparam int SEC_W  = 17;
    localparam int MASK_W = 8;
    localparam int CFG_W  = 4;
    localparam int ERR_W  = 2;
    localparam int TIME_W = 18;

    // Operation codes carried in tuser
    localparam logic OP_ENQ = 1'b0;
    localparam logic OP_RET = 1'b1;

    // Error codes
    localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
    localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_RANGE = 2'd2;

    // Time-of-day constants
    localparam logic [TIME_W-1:0] DAY_SEC     = 18'd86400;
    localparam logic [TIME_W-1:0] MIN_INIT    = 18'd100000;
    localparam logic [SEC_W-1:0]  WRAP_LIMIT  = 17'd86300;
    localparam logic [SEC_W-1:0]  EARLY_LIMIT = 17'd100;

    localparam logic [CFG_W-1:0]  NUM_SRC_RESET = 4'd8;

endpackage
`default_nettype wire

FILE: hdl/tsqm_queue_ram.sv
// Record store for all source queues: one write port, one registered read port.
`default_nettype none
module tsqm_queue_ram #(
    parameter int ADDR_W = 7,
    parameter int DATA_W = 49
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

FILE: hdl/timestamp_sync_queue_merge.sv
// Time-aligned merge of per-source record queues, top level.
//
// Input stream (s_*): one transfer is one operation. s_tuser selects enqueue or
// retrieve; s_tdata carries the source, seconds, payload and connected mask.
// Output stream (m_*): exactly one result transfer per accepted input transfer.
// cfg_wr_en/cfg_wr_data set the number of sources in use; write only while idle.
//
// An enqueue scans the queue heads of all N sources in use (N = sources in use) before
// its result, unless some connected source is still empty; a retrieve always scans all N.
// The scan reads the queue heads through the single registered read port of the
// record memory, one head per cycle.
// One operation is in flight at a time; s_tready is high while no operation is at
// work, also while a finished result still waits in the output register.
// When the receiver stalls, the result holds in m_tdata and the next operation
// completes its work but waits before loading its result.
// Reset clears all queues, the release times and sets the source count to 8; the
// block takes transfers in the first cycle after reset.
`default_nettype none
module timestamp_sync_queue_merge #(
    parameter int MAX_SOURCES   = 8,
    parameter int QUEUE_DEPTH   = 16,
    parameter int PAYLOAD_WIDTH = 32,
    localparam int S_TDATA_W = ((tsqm_pkg::SRC_W + tsqm_pkg::SEC_W + PAYLOAD_WIDTH
                                 + tsqm_pkg::MASK_W + 7) / 8) * 8,
    localparam int M_TDATA_W = ((2 + tsqm_pkg::SRC_W + tsqm_pkg::SEC_W + PAYLOAD_WIDTH
                                 + tsqm_pkg::ERR_W + 7) / 8) * 8
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       cfg_wr_en,
    input  wire logic [tsqm_pkg::CFG_W-1:0] cfg_wr_data,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    // source, record_seconds, payload, connected_mask; zero padded
    input  wire logic [S_TDATA_W-1:0]       s_tdata,
    // operation
    input  wire logic [0:0]                 s_tuser,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // ready_res, found, out_source, out_seconds, out_payload, error; zero padded
    output logic      [M_TDATA_W-1:0]       m_tdata
);

    import tsqm_pkg::*;

    localparam int QW      = $clog2(QUEUE_DEPTH);
    localparam int CW      = $clog2(QUEUE_DEPTH + 1);
    localparam int QSW     = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
    localparam int NW      = $clog2(MAX_SOURCES + 1);
    localparam int CMP_W   = (NW > SRC_W) ? NW : SRC_W;
    localparam int CLW     = (NW > CFG_W) ? NW : CFG_W;
    localparam int ENTRY_W = SEC_W + PAYLOAD_WIDTH;
    localparam int ADDR_W  = QSW + QW;

    localparam int IN_SEC_LO  = SRC_W;
    localparam int IN_PAY_LO  = SRC_W + SEC_W;
    localparam int IN_MASK_LO = IN_PAY_LO + PAYLOAD_WIDTH;

    localparam int OUT_RDY    = 0;
    localparam int OUT_FND    = 1;
    localparam int OUT_SRC_LO = 2;
    localparam int OUT_SEC_LO = OUT_SRC_LO + SRC_W;
    localparam int OUT_PAY_LO = OUT_SEC_LO + SEC_W;
    localparam int OUT_ERR_LO = OUT_PAY_LO + PAYLOAD_WIDTH;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PUSH = 2'd1;
    localparam logic [1:0] ST_SCAN = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    // control state
    logic [1:0]         state_reg, state_next;
    logic [CFG_W-1:0]   num_reg, num_next;
    logic [CW-1:0]      cnt_reg  [MAX_SOURCES];
    logic [CW-1:0]      cnt_next [MAX_SOURCES];
    logic [QW-1:0]      head_reg  [MAX_SOURCES];
    logic [QW-1:0]      head_next [MAX_SOURCES];
    logic [SEC_W-1:0]   release_reg, release_next;
    logic [SEC_W-1:0]   last_rel_reg, last_rel_next;
    logic               m_tvalid_reg, m_tvalid_next;
    logic               rd_vld_reg, rd_vld_next;

    // operation and result holding registers
    logic               op_reg, op_next;
    logic [SRC_W-1:0]   src_reg, src_next;
    logic [SEC_W-1:0]   sec_reg, sec_next;
    logic [PAYLOAD_WIDTH-1:0] pay_reg, pay_next;
    logic [MASK_W-1:0]  mask_reg, mask_next;
    logic [NW-1:0]      issue_reg, issue_next;
    logic [QSW-1:0]     rd_idx_reg, rd_idx_next;
    logic               rd_nz_reg, rd_nz_next;
    logic [TIME_W-1:0]  min_reg, min_next;
    logic               res_ready_reg, res_ready_next;
    logic               res_found_reg, res_found_next;
    logic [SRC_W-1:0]   res_src_reg, res_src_next;
    logic [SEC_W-1:0]   res_sec_reg, res_sec_next;
    logic [PAYLOAD_WIDTH-1:0] res_pay_reg, res_pay_next;
    logic [ERR_W-1:0]   res_err_reg, res_err_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    // datapath
    logic [NW-1:0]      n_eff;
    logic [CLW-1:0]     num_ext;
    logic               in_acc;
    logic [MASK_W-1:0]  in_mask;
    logic [MAX_SOURCES-1:0] in_use, in_conn, reg_conn, cnt_zero;
    logic               all_ok;
    logic [QSW-1:0]     src_idx, sel;
    logic               sel_ok;
    logic [QW-1:0]      head_sel;
    logic [CW-1:0]      cnt_sel;
    logic               src_in_range, push_ok;
    logic [QW:0]        slot_sum;
    logic [QW-1:0]      slot;
    logic               issuing, scan_done, pop;
    logic               wr_en, rd_en;
    logic [ADDR_W-1:0]  wr_addr, rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    logic [SEC_W-1:0]   rd_sec;
    logic [PAYLOAD_WIDTH-1:0] rd_pay;
    logic [TIME_W-1:0]  t_adj, min_fin;
    logic [QW:0]        head_inc;

    // sources in use, clamped to 1..MAX_SOURCES
    always_comb begin
        num_ext = CLW'(num_reg);
        if (num_ext == '0) begin
            n_eff = NW'(1);
        end else if (num_ext > CLW'(MAX_SOURCES)) begin
            n_eff = NW'(MAX_SOURCES);
        end else begin
            n_eff = NW'(num_ext);
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign in_mask  = s_tdata[IN_MASK_LO +: MASK_W];

    genvar g;
    generate
        for (g = 0; g < MAX_SOURCES; g++) begin : g_src
            assign in_use[g]   = (NW'(g) < n_eff);
            assign cnt_zero[g] = (cnt_reg[g] == '0);
            if (g < MASK_W) begin : g_conn
                assign in_conn[g]  = in_mask[g];
                assign reg_conn[g] = mask_reg[g];
            end else begin : g_noconn
                assign in_conn[g]  = 1'b0;
                assign reg_conn[g] = 1'b0;
            end
        end
    endgenerate

    assign all_ok = ~|(in_use & reg_conn & cnt_zero);

    // single index into the per-queue head and count registers
    assign src_idx  = QSW'(src_reg);
    assign issuing  = (state_reg == ST_SCAN) && (issue_reg < n_eff);
    assign sel      = (state_reg == ST_PUSH) ? src_idx : issue_reg[QSW-1:0];
    assign sel_ok   = ((QSW + 1)'(sel) < (QSW + 1)'(MAX_SOURCES));

    always_comb begin
        head_sel = '0;
        cnt_sel  = '0;
        if (sel_ok) begin
            head_sel = head_reg[sel];
            cnt_sel  = cnt_reg[sel];
        end
    end

    assign src_in_range = (CMP_W'(src_reg) < CMP_W'(n_eff));
    assign push_ok      = (state_reg == ST_PUSH) && src_in_range
                          && (cnt_sel < CW'(QUEUE_DEPTH));

    // tail slot = head + count, wrapped once
    always_comb begin
        slot_sum = (QW + 1)'(head_sel) + (QW + 1)'(cnt_sel);
        if (slot_sum >= (QW + 1)'(QUEUE_DEPTH)) begin
            slot_sum = slot_sum - (QW + 1)'(QUEUE_DEPTH);
        end
        slot = slot_sum[QW-1:0];
    end

    assign wr_en   = push_ok;
    assign wr_addr = {src_idx, slot};
    assign rd_en   = issuing;
    assign rd_addr = {sel, head_sel};

    tsqm_queue_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (ENTRY_W)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data ({pay_reg, sec_reg}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign rd_sec = rd_data[SEC_W-1:0];
    assign rd_pay = rd_data[ENTRY_W-1:SEC_W];

    // early-morning heads count as next day once the last popped release time is near midnight
    always_comb begin
        t_adj = TIME_W'(rd_sec);
        if ((last_rel_reg > WRAP_LIMIT) && (rd_sec < EARLY_LIMIT)) begin
            t_adj = TIME_W'(rd_sec) + DAY_SEC;
        end
        min_fin = (min_reg >= DAY_SEC) ? (min_reg - DAY_SEC) : min_reg;
    end

    assign scan_done = (issue_reg >= n_eff) && !rd_vld_reg;
    assign pop       = (state_reg == ST_SCAN) && (op_reg == OP_RET) && rd_vld_reg
                       && rd_nz_reg && !res_found_reg && (rd_sec == release_reg);
    assign head_inc  = (QW + 1)'(head_reg[rd_idx_reg]) + (QW + 1)'(1);

    // per-queue head and count updates: flush on enqueue accept, push, pop
    always_comb begin
        for (int k = 0; k < MAX_SOURCES; k++) begin
            cnt_next[k]  = cnt_reg[k];
            head_next[k] = head_reg[k];
            if (in_acc && (s_tuser[0] == OP_ENQ) && in_use[k] && !in_conn[k]) begin
                cnt_next[k] = '0;
            end
        end
        if (push_ok) begin
            cnt_next[src_idx] = cnt_sel + CW'(1);
        end
        if (pop) begin
            cnt_next[rd_idx_reg]  = cnt_reg[rd_idx_reg] - CW'(1);
            head_next[rd_idx_reg] = (head_inc >= (QW + 1)'(QUEUE_DEPTH)) ? '0
                                                                          : head_inc[QW-1:0];
        end
    end

    // sequencer
    always_comb begin
        state_next     = state_reg;
        num_next       = cfg_wr_en ? cfg_wr_data : num_reg;
        release_next   = release_reg;
        last_rel_next  = last_rel_reg;
        op_next        = op_reg;
        src_next       = src_reg;
        sec_next       = sec_reg;
        pay_next       = pay_reg;
        mask_next      = mask_reg;
        issue_next     = issue_reg;
        rd_vld_next    = 1'b0;
        rd_idx_next    = rd_idx_reg;
        rd_nz_next     = rd_nz_reg;
        min_next       = min_reg;
        res_ready_next = res_ready_reg;
        res_found_next = res_found_reg;
        res_src_next   = res_src_reg;
        res_sec_next   = res_sec_reg;
        res_pay_next   = res_pay_reg;
        res_err_next   = res_err_reg;
        m_tdata_next   = m_tdata_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;

        case (state_reg)
            ST_IDLE: begin
                if (in_acc) begin
                    op_next        = s_tuser[0];
                    src_next       = s_tdata[SRC_W-1:0];
                    sec_next       = s_tdata[IN_SEC_LO +: SEC_W];
                    pay_next       = s_tdata[IN_PAY_LO +: PAYLOAD_WIDTH];
                    mask_next      = in_mask;
                    issue_next     = '0;
                    min_next       = MIN_INIT;
                    res_ready_next = 1'b0;
                    res_found_next = 1'b0;
                    res_src_next   = '0;
                    res_sec_next   = '0;
                    res_pay_next   = '0;
                    res_err_next   = ERR_NONE;
                    state_next     = (s_tuser[0] == OP_ENQ) ? ST_PUSH : ST_SCAN;
                end
            end
            ST_PUSH: begin
                if (!src_in_range) begin
                    res_err_next = ERR_RANGE;
                end else if (!push_ok) begin
                    res_err_next = ERR_FULL;
                end
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                // issue one head read per cycle
                if (issuing) begin
                    rd_vld_next = 1'b1;
                    rd_idx_next = sel;
                    rd_nz_next  = (cnt_sel != '0);
                    issue_next  = issue_reg + NW'(1);
                end
                if (op_reg == OP_ENQ) begin
                    if (rd_vld_reg && rd_nz_reg && (t_adj < min_reg)) begin
                        min_next = t_adj;
                    end
                    if (!all_ok) begin
                        state_next = ST_FIN;
                    end else if (scan_done) begin
                        release_next   = min_fin[SEC_W-1:0];
                        res_ready_next = 1'b1;
                        state_next     = ST_FIN;
                    end
                end else begin
                    if (pop) begin
                        res_found_next = 1'b1;
                        res_src_next   = SRC_W'(rd_idx_reg);
                        res_sec_next   = rd_sec;
                        res_pay_next   = rd_pay;
                        last_rel_next  = release_reg;
                    end
                    if (scan_done) begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_FIN: begin
                // load the result once the output register is free
                if (!m_tvalid_reg || m_tready) begin
                    m_tdata_next                             = '0;
                    m_tdata_next[OUT_RDY]                    = res_ready_reg;
                    m_tdata_next[OUT_FND]                    = res_found_reg;
                    m_tdata_next[OUT_SRC_LO +: SRC_W]        = res_src_reg;
                    m_tdata_next[OUT_SEC_LO +: SEC_W]        = res_sec_reg;
                    m_tdata_next[OUT_PAY_LO +: PAYLOAD_WIDTH] = res_pay_reg;
                    m_tdata_next[OUT_ERR_LO +: ERR_W]        = res_err_reg;
                    m_tvalid_next                            = 1'b1;
                    state_next                               = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            num_reg      <= NUM_SRC_RESET;
            release_reg  <= '0;
            last_rel_reg <= '0;
            m_tvalid_reg <= 1'b0;
            rd_vld_reg   <= 1'b0;
            for (int k = 0; k < MAX_SOURCES; k++) begin
                cnt_reg[k]  <= '0;
                head_reg[k] <= '0;
            end
        end else begin
            state_reg    <= state_next;
            num_reg      <= num_next;
            release_reg  <= release_next;
            last_rel_reg <= last_rel_next;
            m_tvalid_reg <= m_tvalid_next;
            rd_vld_reg   <= rd_vld_next;
            for (int k = 0; k < MAX_SOURCES; k++) begin
                cnt_reg[k]  <= cnt_next[k];
                head_reg[k] <= head_next[k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        src_reg       <= src_next;
        sec_reg       <= sec_next;
        pay_reg       <= pay_next;
        mask_reg      <= mask_next;
        issue_reg     <= issue_next;
        rd_idx_reg    <= rd_idx_next;
        rd_nz_reg     <= rd_nz_next;
        min_reg       <= min_next;
        res_ready_reg <= res_ready_next;
        res_found_reg <= res_found_next;
        res_src_reg   <= res_src_next;
        res_sec_reg   <= res_sec_next;
        res_pay_reg   <= res_pay_next;
        res_err_reg   <= res_err_next;
        m_tdata_reg   <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
`default_nettype wire

FILE: tb/timestamp_sync_queue_merge_tb.sv
// Self-checking testbench for the time-aligned per-source queue merge.
`timescale 1ns / 1ps
module timestamp_sync_queue_merge_tb;
    import tsqm_pkg::*;

    localparam int NSRC       = 8;
    localparam int QDEPTH     = 16;
    localparam int S_W        = 64;
    localparam int M_W        = 56;
    localparam int SETTLE     = 20;
    localparam int HOLD_LEN   = 400;
    localparam int PHASE_OPS  = 125;

    // Result fields, lowest bit last so the struct maps straight onto m_tdata
    typedef struct packed {
        logic [ERR_W-1:0] err;
        logic [31:0]      pay;
        logic [SEC_W-1:0] sec;
        logic [SRC_W-1:0] src;
        logic             found;
        logic             ready;
    } merge_result_t;

    typedef struct packed {
        logic              is_cfg;
        logic              pause_first;
        logic [CFG_W-1:0]  cfg_val;
        logic              op;
        logic [SRC_W-1:0]  src;
        logic [SEC_W-1:0]  sec;
        logic [31:0]       pay;
        logic [MASK_W-1:0] mask;
    } pending_op_t;

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             cfg_wr_en = 1'b0;
    logic [CFG_W-1:0] cfg_wr_data = '0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [S_W-1:0]   s_tdata = '0;
    logic [0:0]       s_tuser = '0;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [M_W-1:0]   m_tdata;

    // Shadow of the queues and release bookkeeping
    logic [SEC_W-1:0] shadow_sec [NSRC][QDEPTH];
    logic [31:0]      shadow_pay [NSRC][QDEPTH];
    int unsigned      shadow_head [NSRC];
    int unsigned      shadow_cnt [NSRC];
    logic [SEC_W-1:0] release_sec;
    logic [SEC_W-1:0] last_release_sec;
    logic [CFG_W-1:0] nsrc_reg;

    pending_op_t   stim_q[$];
    merge_result_t result_q[$];
    pending_op_t   cur_op;

    int unsigned tod_cursor;
    int          accepted_ops = 0;
    int          mismatches = 0;
    int          cfg_writes = 0;
    int          n_enq = 0, n_ret = 0, n_ready = 0, n_found = 0, n_full = 0, n_range = 0;
    int          feed_gap = 0, sink_gap = 0, idle_cycles = 0;
    bit          feed_calm = 1'b0, sink_calm = 1'b0;
    logic        hold_sink = 1'b0;

    timestamp_sync_queue_merge DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #4 aclk = ~aclk;

    function automatic int draw_wait(inout bit calm);
        if ($urandom_range(0, 99) < 4) calm = ~calm;
        return calm ? 0 : int'($urandom_range(0, 12));
    endfunction

    // Apply one operation to the shadow queues and return the result it must produce
    function automatic merge_result_t merge_predict(pending_op_t p);
        merge_result_t r;
        int            n;
        int            i;
        int unsigned   slot, t, mn;
        bit            all_hold;
        r = '0;
        n = int'(nsrc_reg);
        if (n < 1) n = 1;
        if (n > NSRC) n = NSRC;
        if (p.op == OP_ENQ) begin
            n_enq++;
            for (i = 0; i < n; i++)
                if (!p.mask[i]) shadow_cnt[i] = 0;
            if (p.src >= n) begin
                r.err = ERR_RANGE;
            end else if (shadow_cnt[p.src] >= QDEPTH) begin
                r.err = ERR_FULL;
            end else begin
                slot = (shadow_head[p.src] + shadow_cnt[p.src]) % QDEPTH;
                shadow_sec[p.src][slot] = p.sec;
                shadow_pay[p.src][slot] = p.pay;
                shadow_cnt[p.src]++;
            end
            all_hold = 1'b1;
            for (i = 0; i < n; i++)
                if (p.mask[i] && shadow_cnt[i] == 0) all_hold = 1'b0;
            if (all_hold) begin
                mn = 100000;
                for (i = 0; i < n; i++) begin
                    if (shadow_cnt[i] == 0) continue;
                    t = shadow_sec[i][shadow_head[i]];
                    // early heads count as the next day once the last release is near midnight
                    if (last_release_sec > 86300 && t < 100) t += 86400;
                    if (t < mn) mn = t;
                end
                if (mn >= 86400) mn -= 86400;
                release_sec = mn[SEC_W-1:0];
                r.ready = 1'b1;
                n_ready++;
            end
            if (r.err == ERR_FULL) n_full++;
            if (r.err == ERR_RANGE) n_range++;
        end else begin
            n_ret++;
            for (i = 0; i < n; i++) begin
                if (shadow_cnt[i] == 0) continue;
                if (shadow_sec[i][shadow_head[i]] == release_sec) begin
                    r.found = 1'b1;
                    r.src   = i[SRC_W-1:0];
                    r.sec   = shadow_sec[i][shadow_head[i]];
                    r.pay   = shadow_pay[i][shadow_head[i]];
                    shadow_head[i] = (shadow_head[i] + 1) % QDEPTH;
                    shadow_cnt[i]--;
                    last_release_sec = release_sec;
                    n_found++;
                    break;
                end
            end
        end
        return r;
    endfunction

    task automatic push_op(input logic op, input int src, input int sec, input logic [31:0] pay,
                           input logic [7:0] mask);
        pending_op_t p;
        p = '0;
        p.op   = op;
        p.src  = src[SRC_W-1:0];
        p.sec  = sec[SEC_W-1:0];
        p.pay  = pay;
        p.mask = mask;
        stim_q.push_back(p);
    endtask

    task automatic push_cfg(input int val);
        pending_op_t p;
        p = '0;
        p.is_cfg  = 1'b1;
        p.cfg_val = val[CFG_W-1:0];
        stim_q.push_back(p);
    endtask

    // Mostly well-formed traffic around a moving time of day, with some noise
    task automatic add_random_ops(input int count, input int n_eff);
        pending_op_t p;
        int          k;
        for (k = 0; k < count; k++) begin
            p = '0;
            p.pause_first = (k == count / 2) || ($urandom_range(0, 99) == 0);
            if ($urandom_range(0, 99) < 6) begin
                p.op   = 1'($urandom_range(0, 1));
                p.src  = SRC_W'($urandom_range(0, 7));
                p.sec  = SEC_W'($urandom_range(0, 131071));
                p.pay  = $urandom;
                p.mask = MASK_W'($urandom_range(0, 255));
            end else if ($urandom_range(0, 99) < 45) begin
                p.op = OP_RET;
            end else begin
                p.op   = OP_ENQ;
                p.src  = SRC_W'($urandom_range(0, n_eff - 1));
                p.mask = ($urandom_range(0, 19) < 18) ? 8'hFF : 8'($urandom_range(0, 255));
                if ($urandom_range(0, 49) == 0) tod_cursor = $urandom_range(86280, 86399);
                tod_cursor = (tod_cursor + $urandom_range(0, 8)) % 86400;
                p.sec = 17'((tod_cursor + $urandom_range(0, 15)) % 86400);
                p.pay = $urandom;
            end
            stim_q.push_back(p);
        end
    endtask

    // Driver: feeds transfers from stim_q, writes the register only when the block is idle
    always @(posedge aclk) begin
        logic        nxt_valid;
        logic        nxt_cfg_en;
        pending_op_t head;
        if (!aresetn) begin
            s_tvalid  <= 1'b0;
            cfg_wr_en <= 1'b0;
            feed_gap    = 0;
            idle_cycles = 0;
        end else begin
            nxt_valid  = s_tvalid;
            nxt_cfg_en = 1'b0;
            if (s_tvalid && s_tready) begin
                result_q.push_back(merge_predict(cur_op));
                accepted_ops++;
                nxt_valid = 1'b0;
                feed_gap  = draw_wait(feed_calm);
            end
            if (result_q.size() == 0 && !s_tvalid && !cfg_wr_en) idle_cycles++;
            else idle_cycles = 0;
            if (!nxt_valid && stim_q.size() > 0) begin
                if (feed_gap > 0) begin
                    feed_gap--;
                end else begin
                    head = stim_q[0];
                    if ((head.is_cfg || head.pause_first) && idle_cycles < SETTLE) begin
                        // hold until every result is back and the block has settled
                    end else if (head.is_cfg) begin
                        cfg_wr_data <= head.cfg_val;
                        nxt_cfg_en  = 1'b1;
                        nsrc_reg    = head.cfg_val;
                        cfg_writes++;
                        idle_cycles = 0;
                        void'(stim_q.pop_front());
                    end else begin
                        cur_op = head;
                        s_tdata <= {4'b0, head.mask, head.pay, head.sec, head.src};
                        s_tuser <= head.op;
                        nxt_valid = 1'b1;
                        void'(stim_q.pop_front());
                    end
                end
            end
            s_tvalid  <= nxt_valid;
            cfg_wr_en <= nxt_cfg_en;
        end
    end

    // Monitor: checks each result transfer against the oldest prediction
    always @(posedge aclk) begin
        merge_result_t got;
        merge_result_t want;
        logic          nxt_ready;
        if (!aresetn) begin
            m_tready <= 1'b0;
            sink_gap = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = merge_result_t'(m_tdata);
                if (result_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("[%0t] unexpected result transfer: %h", $realtime, m_tdata);
                end else begin
                    want = result_q.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("[%0t] mismatch exp: rdy=%0d fnd=%0d src=%0d sec=%0d",
                                     $realtime, want.ready, want.found, want.src, want.sec);
                            $display("    exp pay=%h err=%0d", want.pay, want.err);
                            $display("    got: rdy=%0d fnd=%0d src=%0d sec=%0d pay=%h err=%0d",
                                     got.ready, got.found, got.src, got.sec, got.pay, got.err);
                        end
                    end
                end
                sink_gap = draw_wait(sink_calm);
            end
            if (hold_sink) begin
                nxt_ready = 1'b0;
            end else if (sink_gap > 0) begin
                sink_gap--;
                nxt_ready = 1'b0;
            end else begin
                nxt_ready = 1'b1;
            end
            m_tready <= nxt_ready;
        end
    end

    // Long receiver stall while the sender keeps offering, so the input backs up
    initial begin
        wait (accepted_ops >= 450);
        @(posedge aclk);
        hold_sink <= 1'b1;
        repeat (HOLD_LEN) @(posedge aclk);
        hold_sink <= 1'b0;
    end

    initial begin
        #5_000_000;
        $display("Timeout with %0d results outstanding", result_q.size());
        $display("Mismatches found");
        $finish;
    end

    initial begin
        int i;
        int phase_cfg [8];
        int eff;
        phase_cfg = '{15, 3, 0, 8, 5, 2, 7, 8};
        for (i = 0; i < NSRC; i++) begin
            shadow_head[i] = 0;
            shadow_cnt[i]  = 0;
        end
        release_sec      = '0;
        last_release_sec = '0;
        nsrc_reg         = NUM_SRC_RESET;
        tod_cursor       = $urandom_range(0, 86399);

        // Directed: empty retrieve, no source connected, field extremes, midnight wrap
        push_op(OP_RET, 0, 0, 32'h0, 8'h00);
        push_op(OP_ENQ, 0, 0, 32'h0, 8'h00);
        push_op(OP_ENQ, 7, 131071, 32'hFFFF_FFFF, 8'h81);
        push_op(OP_RET, 0, 0, 32'h0, 8'h00);
        push_op(OP_RET, 0, 0, 32'h0, 8'h00);
        push_op(OP_ENQ, 1, 86350, 32'hA5A5_5A5A, 8'h02);
        push_op(OP_RET, 0, 0, 32'h0, 8'h00);
        push_op(OP_ENQ, 1, 50, 32'h1234_5678, 8'h02);
        push_op(OP_RET, 0, 0, 32'h0, 8'h00);
        // Directed: one source in use, overfill its queue, then an unused source
        push_cfg(1);
        push_op(OP_ENQ, 0, 10, 32'h0000_0001, 8'hFE);
        for (i = 0; i < QDEPTH; i++)
            push_op(OP_ENQ, 0, 11 + i, $urandom, 8'h01);
        push_op(OP_ENQ, 5, 40, 32'hDEAD_BEEF, 8'hFF);
        push_op(OP_RET, 0, 0, 32'h0, 8'h00);

        foreach (phase_cfg[k]) begin
            eff = phase_cfg[k];
            if (eff < 1) eff = 1;
            if (eff > NSRC) eff = NSRC;
            push_cfg(phase_cfg[k]);
            add_random_ops(PHASE_OPS, eff);
        end

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        while (stim_q.size() != 0 || s_tvalid) @(posedge aclk);
        while (result_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);

        $display("Covered %0d enqueues and %0d retrieves over %0d register writes",
                 n_enq, n_ret, cfg_writes);
        $display("Saw %0d ready, %0d popped, %0d dropped full, %0d out of range; %0d mismatches",
                 n_ready, n_found, n_full, n_range, mismatches);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
